// ===== hdl/fbde_pkg.sv =====
// fbde_pkg: shared constants, opcodes, request layout and the command and status
// structs that run between the draw engine controller and its datapath.
// No dependencies; every other file of the draw engine imports this package.
package fbde_pkg;

    // default screen geometry
    localparam int DEF_SCREEN_WIDTH  = 240;
    localparam int DEF_SCREEN_HEIGHT = 160;

    // request and result field widths
    localparam int OP_W    = 3;
    localparam int FIELD_W = 8;
    localparam int COLOR_W = 16;

    // signed pixel coordinate: spans -1 up to twice the largest field value
    localparam int COORD_W = 12;
    // line decision variable
    localparam int D_W     = 20;

    typedef enum logic [OP_W-1:0] {
        OP_SET    = 3'd0,
        OP_FILL   = 3'd1,
        OP_HOLLOW = 3'd2,
        OP_LINE   = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    // which pixel walk the datapath loads
    typedef enum logic [2:0] {
        SEL_PIXEL  = 3'd0,
        SEL_FILL   = 3'd1,
        SEL_TOP    = 3'd2,
        SEL_BOTTOM = 3'd3,
        SEL_LEFT   = 3'd4,
        SEL_RIGHT  = 3'd5,
        SEL_LINE   = 3'd6
    } span_sel_t;

    // how the walk advances from one pixel to the next
    typedef enum logic [1:0] {
        MODE_H    = 2'd0,
        MODE_V    = 2'd1,
        MODE_FILL = 2'd2,
        MODE_LINE = 2'd3
    } walk_mode_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] height;
        logic [FIELD_W-1:0] end_col;
        logic [FIELD_W-1:0] end_row;
        logic [COLOR_W-1:0] color;
    } fbde_req_item_t;

    typedef struct packed {
        logic      load;      // capture the accepted request
        logic      start;     // load a new walk
        span_sel_t sel;       // walk to load
        logic      step;      // write the current pixel and advance
        logic      rd_addr;   // latch the read address
        logic      rsp_load;  // load the result register
    } fbde_cmd_t;

    typedef struct packed {
        op_t  op;
        logic w_zero;
        logic h_zero;
        logic last;           // current pixel is the last one of the walk
    } fbde_status_t;

endpackage

// ===== hdl/fbde_req_if.sv =====
// fbde_req_if: request channel of the draw engine, valid/ready plus command fields.
// Depends on fbde_pkg for the field widths.
interface fbde_req_if import fbde_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
    logic [FIELD_W-1:0] end_col;
    logic [FIELD_W-1:0] end_row;
    logic [COLOR_W-1:0] color;

    modport source (
        output valid, op, row, col, width, height, end_col, end_row, color,
        input  ready
    );

    modport sink (
        input  valid, op, row, col, width, height, end_col, end_row, color,
        output ready
    );

endinterface

// ===== hdl/fbde_rsp_if.sv =====
// fbde_rsp_if: result channel of the draw engine, valid/ready plus read data.
// Depends on fbde_pkg for the data width.
interface fbde_rsp_if import fbde_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );

    modport sink (
        input  valid, read_data,
        output ready
    );

endinterface

// ===== hdl/fbde_ctrl.sv =====
// fbde_ctrl: command sequencer of the draw engine; walks each request through
// its pixel spans and owns the result valid register.
// Depends on fbde_pkg for the command and status structs.
module fbde_ctrl import fbde_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  fbde_status_t status,
    output fbde_cmd_t    cmd
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_DISPATCH = 10'b00_0000_0010,
        ST_RUN      = 10'b00_0000_0100,
        ST_H_TOP    = 10'b00_0000_1000,
        ST_H_BOT    = 10'b00_0001_0000,
        ST_H_LEFT   = 10'b00_0010_0000,
        ST_H_RIGHT  = 10'b00_0100_0000,
        ST_RD_ADDR  = 10'b00_1000_0000,
        ST_RD_MEM   = 10'b01_0000_0000,
        ST_FINISH   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // result slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    OP_SET:
                    begin
                        cmd.start  = 1'b1;
                        cmd.sel    = SEL_PIXEL;
                        state_next = ST_RUN;
                    end
                    OP_FILL:
                    begin
                        if (status.w_zero || status.h_zero)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            cmd.sel    = SEL_FILL;
                            state_next = ST_RUN;
                        end
                    end
                    OP_HOLLOW:
                    begin
                        if (!status.w_zero)
                        begin
                            cmd.start  = 1'b1;
                            cmd.sel    = SEL_TOP;
                            state_next = ST_H_TOP;
                        end
                        else if (!status.h_zero)
                        begin
                            cmd.start  = 1'b1;
                            cmd.sel    = SEL_LEFT;
                            state_next = ST_H_LEFT;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    OP_LINE:
                    begin
                        cmd.start  = 1'b1;
                        cmd.sel    = SEL_LINE;
                        state_next = ST_RUN;
                    end
                    OP_READ:
                    begin
                        cmd.start  = 1'b1;
                        cmd.sel    = SEL_PIXEL;
                        state_next = ST_RD_ADDR;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            // outline: top, bottom, left, right; next span loads with the last pixel
            ST_H_TOP:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_BOTTOM;
                    state_next = ST_H_BOT;
                end
            end
            ST_H_BOT:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    if (status.h_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.sel    = SEL_LEFT;
                        state_next = ST_H_LEFT;
                    end
                end
            end
            ST_H_LEFT:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_RIGHT;
                    state_next = ST_H_RIGHT;
                end
            end
            ST_H_RIGHT:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RD_ADDR:
            begin
                cmd.rd_addr = 1'b1;
                state_next  = ST_RD_MEM;
            end
            ST_RD_MEM:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.rsp_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/fbde_dp.sv =====
// fbde_dp: draw engine datapath; request registers, pixel walker, line stepper,
// address multiply, frame store and result data register.
// Depends on fbde_pkg for types and widths.
module fbde_dp import fbde_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fbde_req_item_t      item,
    input  fbde_cmd_t           cmd,
    output fbde_status_t        status,
    output logic [COLOR_W-1:0]  read_data
);

    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = COORD_W - 1;
    localparam int MUL_W  = 2 * IDX_W;
    localparam int EXT_W  = COORD_W - FIELD_W;
    localparam logic signed [COORD_W-1:0] C_ONE = COORD_W'(1);

    function automatic logic signed [D_W-1:0] sext_d(input logic signed [COORD_W-1:0] v);
        sext_d = {{(D_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // request registers
    op_t                 op_reg;
    logic [FIELD_W-1:0]  row_reg;
    logic [FIELD_W-1:0]  col_reg;
    logic [FIELD_W-1:0]  w_reg;
    logic [FIELD_W-1:0]  h_reg;
    logic [FIELD_W-1:0]  ecol_reg;
    logic [FIELD_W-1:0]  erow_reg;
    logic [COLOR_W-1:0]  color_reg;

    // walker state
    logic signed [COORD_W-1:0] cur_r_reg, cur_r_next;
    logic signed [COORD_W-1:0] cur_c_reg, cur_c_next;
    logic [FIELD_W-1:0]        cnt_reg, cnt_next;
    logic [FIELD_W-1:0]        rows_reg, rows_next;
    walk_mode_t                mode_reg, mode_next;
    logic signed [D_W-1:0]     d_reg, d_next;
    logic signed [COORD_W-1:0] dflat_reg, dflat_next;
    logic signed [COORD_W-1:0] ddiag_reg, ddiag_next;

    // write/read port
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               ok_reg;
    logic               wr_en_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic [COLOR_W-1:0] rsp_data_reg;
    logic [COLOR_W-1:0] mem [DEPTH];

    logic signed [COORD_W-1:0] row_x, col_x, w_x, h_x, ecol_x, erow_x, dx, dy;
    logic [MUL_W-1:0]          row_base;
    logic [MUL_W-1:0]          addr_full;
    logic                      in_bounds;
    logic                      d_pos;

    // capture the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(item.op);
            row_reg   <= item.row;
            col_reg   <= item.col;
            w_reg     <= item.width;
            h_reg     <= item.height;
            ecol_reg  <= item.end_col;
            erow_reg  <= item.end_row;
            color_reg <= item.color;
        end
    end

    // request fields as signed coordinates
    assign row_x  = {{EXT_W{1'b0}}, row_reg};
    assign col_x  = {{EXT_W{1'b0}}, col_reg};
    assign w_x    = {{EXT_W{1'b0}}, w_reg};
    assign h_x    = {{EXT_W{1'b0}}, h_reg};
    assign ecol_x = {{EXT_W{1'b0}}, ecol_reg};
    assign erow_x = {{EXT_W{1'b0}}, erow_reg};
    assign dx     = ecol_x - col_x;
    assign dy     = erow_x - row_x;
    assign d_pos  = !d_reg[D_W-1] && (d_reg != '0);

    // walker: load a new span or advance one pixel
    always_comb
    begin
        cur_r_next = cur_r_reg;
        cur_c_next = cur_c_reg;
        cnt_next   = cnt_reg;
        rows_next  = rows_reg;
        mode_next  = mode_reg;
        d_next     = d_reg;
        dflat_next = dflat_reg;
        ddiag_next = ddiag_reg;
        if (cmd.start)
        begin
            cur_r_next = row_x;
            cur_c_next = col_x;
            cnt_next   = w_reg - FIELD_W'(1);
            rows_next  = h_reg - FIELD_W'(1);
            mode_next  = MODE_H;
            case (cmd.sel)
                SEL_PIXEL:
                begin
                    cnt_next = '0;
                end
                SEL_FILL:
                begin
                    mode_next = MODE_FILL;
                end
                SEL_TOP:
                begin
                    mode_next = MODE_H;
                end
                SEL_BOTTOM:
                begin
                    cur_r_next = row_x + h_x - C_ONE;
                end
                SEL_LEFT:
                begin
                    cnt_next  = h_reg - FIELD_W'(1);
                    mode_next = MODE_V;
                end
                SEL_RIGHT:
                begin
                    cur_c_next = col_x + w_x - C_ONE;
                    cnt_next   = h_reg - FIELD_W'(1);
                    mode_next  = MODE_V;
                end
                SEL_LINE:
                begin
                    // a backward line keeps only its start pixel
                    cnt_next   = dx[COORD_W-1] ? '0 : dx[FIELD_W-1:0];
                    mode_next  = MODE_LINE;
                    d_next     = sext_d(dy <<< 1) - sext_d(dx);
                    dflat_next = dy <<< 1;
                    ddiag_next = (dy - dx) <<< 1;
                end
                default:
                begin
                    cnt_next = '0;
                end
            endcase
        end
        else if (cmd.step)
        begin
            case (mode_reg)
                MODE_H:
                begin
                    cur_c_next = cur_c_reg + C_ONE;
                    cnt_next   = cnt_reg - FIELD_W'(1);
                end
                MODE_V:
                begin
                    cur_r_next = cur_r_reg + C_ONE;
                    cnt_next   = cnt_reg - FIELD_W'(1);
                end
                MODE_FILL:
                begin
                    // wrap to the left edge of the next row
                    if (cnt_reg == '0)
                    begin
                        cur_c_next = col_x;
                        cnt_next   = w_reg - FIELD_W'(1);
                        cur_r_next = cur_r_reg + C_ONE;
                        rows_next  = rows_reg - FIELD_W'(1);
                    end
                    else
                    begin
                        cur_c_next = cur_c_reg + C_ONE;
                        cnt_next   = cnt_reg - FIELD_W'(1);
                    end
                end
                MODE_LINE:
                begin
                    cur_c_next = cur_c_reg + C_ONE;
                    cnt_next   = cnt_reg - FIELD_W'(1);
                    if (d_pos)
                    begin
                        cur_r_next = cur_r_reg + C_ONE;
                        d_next     = d_reg + sext_d(ddiag_reg);
                    end
                    else
                    begin
                        d_next = d_reg + sext_d(dflat_reg);
                    end
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cur_r_reg <= cur_r_next;
        cur_c_reg <= cur_c_next;
        cnt_reg   <= cnt_next;
        rows_reg  <= rows_next;
        d_reg     <= d_next;
        dflat_reg <= dflat_next;
        ddiag_reg <= ddiag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_H;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // status back to the controller
    assign status.op     = op_reg;
    assign status.w_zero = (w_reg == '0);
    assign status.h_zero = (h_reg == '0);
    assign status.last   = (cnt_reg == '0) && ((mode_reg != MODE_FILL) || (rows_reg == '0));

    // screen clip and row-major address
    assign in_bounds = !cur_r_reg[COORD_W-1] && !cur_c_reg[COORD_W-1]
                       && (cur_r_reg[IDX_W-1:0] < IDX_W'(SCREEN_HEIGHT))
                       && (cur_c_reg[IDX_W-1:0] < IDX_W'(SCREEN_WIDTH));
    assign row_base  = MUL_W'(cur_r_reg[IDX_W-1:0]) * MUL_W'(SCREEN_WIDTH);
    assign addr_full = row_base + MUL_W'(cur_c_reg[IDX_W-1:0]);
    assign addr_next = ADDR_W'(addr_full);

    // write request register, one pixel per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_en_reg <= 1'b0;
        end
        else
        begin
            wr_en_reg <= cmd.step && in_bounds;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step || cmd.rd_addr)
        begin
            addr_reg <= addr_next;
            ok_reg   <= in_bounds;
        end
    end

    // frame store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[addr_reg] <= color_reg;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // result data, zero unless an on-screen read
    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_data_reg <= ((op_reg == OP_READ) && ok_reg) ? rd_data_reg : '0;
        end
    end

    assign read_data = rsp_data_reg;

endmodule

// ===== hdl/frame_buffer_draw_engine.sv =====
// frame_buffer_draw_engine: top level; ties the request and result channels to
// the controller (fbde_ctrl) and the datapath with the frame store (fbde_dp).
// Depends on fbde_pkg, fbde_req_if and fbde_rsp_if.
//
//   channel  dir  payload                                        handshake
//   req      in   op row col width height end_col end_row color  valid/ready
//   rsp      out  read_data                                      valid/ready
//
// One request at a time. Each command is captured, dispatched, walked pixel by pixel
// over its spans (a read instead latches its address and reads the frame store) and
// finished before the next acceptance; the single frame store write port writes one
// pixel per cycle. A pending result sits in its own register, so the next request is
// taken while rsp is stalled; a new result waits for the slot.
// rst_n clears control state only; frame store contents are undefined until written.
module frame_buffer_draw_engine import fbde_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    fbde_req_if.sink    req,
    fbde_rsp_if.source  rsp
);

    fbde_req_item_t     item;
    fbde_cmd_t          cmd;
    fbde_status_t       status;
    logic               in_ready;
    logic               out_valid;
    logic [COLOR_W-1:0] read_data;

    // request fields gathered into one struct
    assign item.op      = req.op;
    assign item.row     = req.row;
    assign item.col     = req.col;
    assign item.width   = req.width;
    assign item.height  = req.height;
    assign item.end_col = req.end_col;
    assign item.end_row = req.end_row;
    assign item.color   = req.color;

    fbde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    fbde_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .read_data (read_data)
    );

    assign req.ready     = in_ready;
    assign rsp.valid     = out_valid;
    assign rsp.read_data = read_data;

    // no pixel walk while requests are being taken
    a_no_step_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.step)
        else $error("pixel step while accepting requests");

    // an accepted request is dispatched before any pixel is written
    a_no_step_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (!cmd.step && !in_ready))
        else $error("step or ready right after request capture");

    // a finished walk with no follow-on span stops stepping
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.last && !cmd.start) |=> !cmd.step)
        else $error("pixel walk ran past its last pixel");

    // loading a result always presents it
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |=> out_valid)
        else $error("result loaded but not presented");

endmodule

// ===== dv/tb_frame_buffer_draw_engine.sv =====
`timescale 1ns / 1ps
// tb_frame_buffer_draw_engine: self-checking bench for the frame buffer draw engine; a shadow
// frame store predicts the read data of every request and results are checked in order.
// Depends on fbde_pkg, fbde_req_if, fbde_rsp_if and frame_buffer_draw_engine.
module tb_frame_buffer_draw_engine;
    import fbde_pkg::*;

    localparam int SCR_W = DEF_SCREEN_WIDTH;
    localparam int SCR_H = DEF_SCREEN_HEIGHT;
    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_REQS = 2000;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_W'(OP_READ + 1);
    localparam logic [OP_W-1:0] OP_SPARE_LAST = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fbde_req_if req_ch ();
    fbde_rsp_if rsp_ch ();

    frame_buffer_draw_engine DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow of the frame store and the read data still owed by the engine
    logic [COLOR_W-1:0] shadow_frame [SCR_W*SCR_H];
    logic [COLOR_W-1:0] pending_read_data [$];
    logic [COLOR_W-1:0] expected_rd;
    int mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit idle_en = 1'b1;
    int last_row = 0;
    int last_col = 0;

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // ---------------------------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------------------------

    // write one pixel, skipping anything off screen
    function automatic void plot(int r, int c, logic [COLOR_W-1:0] color);
        if (r < 0 || c < 0 || r >= SCR_H || c >= SCR_W)
            return;
        shadow_frame[r * SCR_W + c] = color;
    endfunction

    // apply one request to the shadow frame and return the read data it yields
    function automatic logic [COLOR_W-1:0] render_cmd(fbde_req_item_t cmd);
        int r, c, w, h, ec, er;
        int x, y, dx, dy, d;
        logic [COLOR_W-1:0] rd;
        r = int'(cmd.row);
        c = int'(cmd.col);
        w = int'(cmd.width);
        h = int'(cmd.height);
        ec = int'(cmd.end_col);
        er = int'(cmd.end_row);
        rd = '0;
        case (cmd.op)
            OP_SET:
                plot(r, c, cmd.color);
            OP_FILL:
            begin
                for (x = c; x < c + w; x++)
                    for (y = r; y < r + h; y++)
                        plot(y, x, cmd.color);
            end
            OP_HOLLOW:
            begin
                // top, bottom, left, right spans; a zero size puts the far edge one before the start
                for (x = c; x < c + w; x++)
                    plot(r, x, cmd.color);
                for (x = c; x < c + w; x++)
                    plot(r + h - 1, x, cmd.color);
                for (y = r; y < r + h; y++)
                    plot(y, c, cmd.color);
                for (y = r; y < r + h; y++)
                    plot(y, c + w - 1, cmd.color);
            end
            OP_LINE:
            begin
                // first-octant rule, no correction for other slopes
                dx = ec - c;
                dy = er - r;
                d = 2 * dy - dx;
                y = r;
                plot(r, c, cmd.color);
                for (x = c + 1; x <= ec; x++)
                begin
                    if (d > 0)
                    begin
                        y = y + 1;
                        plot(y, x, cmd.color);
                        d = d + 2 * dy - 2 * dx;
                    end
                    else
                    begin
                        plot(y, x, cmd.color);
                        d = d + 2 * dy;
                    end
                end
            end
            OP_READ:
            begin
                if (r < SCR_H && c < SCR_W)
                    rd = shadow_frame[r * SCR_W + c];
            end
            default:
                rd = '0;
        endcase
        return rd;
    endfunction

    // ---------------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic fbde_req_item_t make_cmd(logic [OP_W-1:0] op, int row, int col,
                                                 int width, int height, int end_col,
                                                 int end_row, int color);
        fbde_req_item_t cmd;
        cmd.op = op;
        cmd.row = FIELD_W'(row);
        cmd.col = FIELD_W'(col);
        cmd.width = FIELD_W'(width);
        cmd.height = FIELD_W'(height);
        cmd.end_col = FIELD_W'(end_col);
        cmd.end_row = FIELD_W'(end_row);
        cmd.color = COLOR_W'(color);
        return cmd;
    endfunction

    // drive one request, wait for the handshake, then record its expected read data
    task automatic send_req(fbde_req_item_t cmd);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.op <= cmd.op;
        req_ch.row <= cmd.row;
        req_ch.col <= cmd.col;
        req_ch.width <= cmd.width;
        req_ch.height <= cmd.height;
        req_ch.end_col <= cmd.end_col;
        req_ch.end_row <= cmd.end_row;
        req_ch.color <= cmd.color;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_read_data.push_back(render_cmd(cmd));
        if (cmd.op < OP_READ)
        begin
            last_row = int'(cmd.row);
            last_col = int'(cmd.col);
        end
    endtask

    // ---------------------------------------------------------------------------------------
    // result side: random stalls and in-order check
    // ---------------------------------------------------------------------------------------

    function automatic void report_mismatch(string what, logic [COLOR_W-1:0] want,
                                            logic [COLOR_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s, expected %h, got %h",
                     cycle_count, what, want, got);
    endfunction

    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (idle_en && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_read_data.size() == 0)
                report_mismatch("result with no request outstanding", '0, rsp_ch.read_data);
            else
            begin
                expected_rd = pending_read_data.pop_front();
                if (rsp_ch.read_data !== expected_rd)
                    report_mismatch("read_data", expected_rd, rsp_ch.read_data);
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------------

    // full screen fill first so that every later on-screen read hits a written pixel
    task automatic test_fill_rect();
        send_req(make_cmd(OP_FILL, 0, 0, SCR_W, SCR_H, 0, 0, 16'h5AA5));
        send_req(make_cmd(OP_READ, 80, 120, 0, 0, 0, 0, 0));
        send_req(make_cmd(OP_FILL, 10, 10, 0, 7, 0, 0, 16'h1234));
        send_req(make_cmd(OP_FILL, 10, 10, 7, 0, 0, 0, 16'h4321));
        // largest sizes, mostly off screen
        send_req(make_cmd(OP_FILL, 100, 200, 255, 255, 0, 0, 16'hFFFF));
        send_req(make_cmd(OP_READ, SCR_H - 1, SCR_W - 1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_set_and_read();
        send_req(make_cmd(OP_SET, 0, 0, 255, 255, 255, 255, 16'hFFFF));
        send_req(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_cmd(OP_SET, SCR_H - 1, SCR_W - 1, 0, 0, 0, 0, 16'h0000));
        send_req(make_cmd(OP_READ, SCR_H - 1, SCR_W - 1, 0, 0, 0, 0, 0));
        // off screen write and reads
        send_req(make_cmd(OP_SET, 255, 255, 0, 0, 0, 0, 16'hBEEF));
        send_req(make_cmd(OP_READ, 255, 255, 0, 0, 0, 0, 0));
        send_req(make_cmd(OP_READ, SCR_H, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_hollow_rect();
        send_req(make_cmd(OP_HOLLOW, 30, 30, 1, 1, 0, 0, 16'h00FF));
        // zero width puts the right edge at column -1
        send_req(make_cmd(OP_HOLLOW, 40, 0, 0, 5, 0, 0, 16'h0F0F));
        // zero height puts the bottom edge at row r-1
        send_req(make_cmd(OP_HOLLOW, 0, 50, 6, 0, 0, 0, 16'hF0F0));
        send_req(make_cmd(OP_HOLLOW, 150, 230, 20, 20, 0, 0, 16'h8001));
        send_req(make_cmd(OP_READ, 43, 0, 0, 0, 0, 0, 0));
        send_req(make_cmd(OP_READ, 150, 235, 0, 0, 0, 0, 0));
    endtask

    task automatic test_line();
        send_req(make_cmd(OP_LINE, 5, 0, 0, 0, SCR_W - 1, 60, 16'h7E7E));
        // backward line draws only its start pixel
        send_req(make_cmd(OP_LINE, 70, 100, 0, 0, 50, 70, 16'h1111));
        // steep and upward lines use the same rule uncorrected
        send_req(make_cmd(OP_LINE, 80, 10, 0, 0, 14, 140, 16'h2222));
        send_req(make_cmd(OP_LINE, 120, 20, 0, 0, 60, 90, 16'h3333));
        send_req(make_cmd(OP_LINE, 150, 200, 0, 0, 255, 255, 16'h4444));
        send_req(make_cmd(OP_READ, 81, 11, 0, 0, 0, 0, 0));
    endtask

    task automatic test_spare_ops();
        send_req(make_cmd(OP_SPARE_FIRST, 20, 20, 4, 4, 30, 30, 16'hDEAD));
        send_req(make_cmd(OP_SPARE_LAST, 20, 20, 4, 4, 30, 30, 16'hDEAD));
        send_req(make_cmd(OP_READ, 20, 20, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_mix();
        fbde_req_item_t cmd;
        int issued, p, q, dx;
        issued = 0;
        while (issued < RANDOM_REQS)
        begin
            // stretches with idling on both sides, then stretches without
            idle_en = (issued % 150) < 120;
            cmd.row = FIELD_W'($urandom);
            cmd.col = FIELD_W'($urandom);
            cmd.width = FIELD_W'($urandom);
            cmd.height = FIELD_W'($urandom);
            cmd.end_col = FIELD_W'($urandom);
            cmd.end_row = FIELD_W'($urandom);
            cmd.color = COLOR_W'($urandom);
            p = $urandom_range(0, 99);
            if (p < 14)
                cmd.op = OP_SET;
            else if (p < 28)
                cmd.op = OP_FILL;
            else if (p < 42)
                cmd.op = OP_HOLLOW;
            else if (p < 62)
                cmd.op = OP_LINE;
            else if (p < 95)
                cmd.op = OP_READ;
            else
                cmd.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

            // most requests start on screen, the rest anywhere the fields allow
            if ($urandom_range(0, 9) != 0)
            begin
                cmd.row = FIELD_W'($urandom_range(0, SCR_H - 1));
                cmd.col = FIELD_W'($urandom_range(0, SCR_W - 1));
            end

            // sizes: small mostly, one long side now and then
            q = $urandom_range(0, 99);
            if (q < 85)
            begin
                cmd.width = FIELD_W'($urandom_range(0, 12));
                cmd.height = FIELD_W'($urandom_range(0, 12));
            end
            else if (q < 97)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    cmd.width = FIELD_W'($urandom_range(0, 255));
                    cmd.height = FIELD_W'($urandom_range(0, 8));
                end
                else
                begin
                    cmd.width = FIELD_W'($urandom_range(0, 8));
                    cmd.height = FIELD_W'($urandom_range(0, 255));
                end
            end
            else
            begin
                cmd.width = FIELD_W'($urandom_range(0, 48));
                cmd.height = FIELD_W'($urandom_range(0, 48));
            end

            // lines: mostly first-octant, some random ends, some backward
            if (cmd.op == OP_LINE)
            begin
                q = $urandom_range(0, 9);
                if (q < 7)
                begin
                    dx = $urandom_range(0, 60);
                    if (int'(cmd.col) + dx > 255)
                        dx = 255 - int'(cmd.col);
                    cmd.end_col = FIELD_W'(int'(cmd.col) + dx);
                    q = int'(cmd.row) + $urandom_range(0, dx);
                    cmd.end_row = FIELD_W'(q > 255 ? 255 : q);
                end
                else if (q >= 8 && cmd.col > 0)
                    cmd.end_col = FIELD_W'(int'(cmd.col) - $urandom_range(1, int'(cmd.col)));
            end

            // reads: half of them on the last drawn start pixel
            if (cmd.op == OP_READ && $urandom_range(0, 1) == 0)
            begin
                cmd.row = FIELD_W'(last_row);
                cmd.col = FIELD_W'(last_col);
            end

            send_req(cmd);
            if (cmd.op <= OP_READ)
                issued++;
        end
        idle_en = 1'b1;
    endtask

    // ---------------------------------------------------------------------------------------
    // sequence and end of run
    // ---------------------------------------------------------------------------------------

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_frame_buffer_draw_engine NOT OK");
        $finish;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.op = OP_SET;
        req_ch.row = '0;
        req_ch.col = '0;
        req_ch.width = '0;
        req_ch.height = '0;
        req_ch.end_col = '0;
        req_ch.end_row = '0;
        req_ch.color = '0;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_fill_rect();
        test_set_and_read();
        test_hollow_rect();
        test_line();
        test_spare_ops();
        test_random_mix();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        // poll until every owed result has come back
        while (pending_read_data.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_read_data.size() != 0)
        begin
            $display("%0d results never arrived", pending_read_data.size());
            mismatch_count += pending_read_data.size();
        end

        if (mismatch_count == 0)
            $display("tb_frame_buffer_draw_engine OK");
        else
            $display("tb_frame_buffer_draw_engine NOT OK");
        $finish;
    end

endmodule
